/* hw/rtl/torus_mesh_cell_generator_assert.svh */
// ----------------------------------------------------------------------------
// Torus mesh cell generator assertion macros
// Shared assertion macros; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TORUS_MESH_CELL_GENERATOR_ASSERT_SVH
`define TORUS_MESH_CELL_GENERATOR_ASSERT_SVH
`ifndef SYNTH
`define TMCG_ASSERT_IMP(lbl, aclk, arst_n, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!arst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TMCG_ASSERT_ALWAYS(lbl, aclk, arst_n, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!arst_n) (cond)) \
        else $error(msg);
`else
`define TMCG_ASSERT_IMP(lbl, aclk, arst_n, ante, cons, msg)
`define TMCG_ASSERT_ALWAYS(lbl, aclk, arst_n, cond, msg)
`endif
`endif

/* hw/rtl/tmcg_pkg.sv */
// ----------------------------------------------------------------------------
// Torus mesh cell generator package
// Shared widths, codes, word formats and arithmetic helpers.
// ----------------------------------------------------------------------------
package tmcg_pkg;

    localparam int CNT_W  = 9;
    localparam int IDX_W  = 8;
    localparam int PH_W   = 32;
    localparam int POS_W  = 19;
    localparam int NRM_W  = 16;
    localparam int TEX_W  = 16;
    localparam int VID_W  = 16;
    localparam int RAD_W  = 16;
    localparam int KIND_W = 2;
    localparam int T_W    = 31;

    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = PH_W / DIV_BITS;

    localparam logic [KIND_W-1:0] KIND_VERTEX = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRI1   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRI2   = 2'd2;

    localparam logic [1:0] REG_SLICES = 2'd0;
    localparam logic [1:0] REG_STACKS = 2'd1;
    localparam logic [1:0] REG_MAJOR  = 2'd2;
    localparam logic [1:0] REG_TUBE   = 2'd3;

    localparam logic [T_W-1:0] ONE_Q30 = 31'd1073741824;
    localparam logic [T_W-1:0] SC1 = 31'd1686629713;
    localparam logic [T_W-1:0] SC3 = 31'd693598667;
    localparam logic [T_W-1:0] SC5 = 31'd85569306;
    localparam logic [T_W-1:0] SC7 = 31'd5026995;
    localparam logic [T_W-1:0] SC9 = 31'd172272;

    localparam logic [PH_W-1:0] QUARTER_TURN = 32'h4000_0000;

    typedef struct packed {
        logic [CNT_W-1:0] slices;
        logic [CNT_W-1:0] stacks;
    } grid_cfg_t;

    typedef struct packed {
        logic [RAD_W-1:0] major;
        logic [RAD_W-1:0] tube;
    } geom_cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] rem;
        logic [PH_W-1:0]  quo;
    } dstep_t;

    typedef struct packed {
        dstep_t a;
        dstep_t b;
    } div_t;

    typedef struct packed {
        logic [VID_W-1:0] cur;
        logic [VID_W-1:0] nstack;
        logic [VID_W-1:0] nslice;
        logic [VID_W-1:0] nboth;
    } idx_t;

    typedef struct packed {
        logic [PH_W-1:0] pa;
        logic [PH_W-1:0] pb;
        idx_t            idx;
    } mid_t;

    typedef struct packed {
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        idx_t             idx;
    } side_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [NRM_W-1:0] norm_x;
        logic signed [NRM_W-1:0] norm_y;
        logic signed [NRM_W-1:0] norm_z;
        side_t                   side;
    } out_t;

    function automatic dstep_t div_step(dstep_t s, logic [CNT_W-1:0] den);
        dstep_t        res;
        logic [CNT_W:0] sh;
        res = s;
        for (int k = 0; k < DIV_BITS; k++) begin
            sh = {res.rem, 1'b0};
            if (sh >= {1'b0, den}) begin
                sh = sh - {1'b0, den};
                res.quo = {res.quo[PH_W-2:0], 1'b1};
            end
            else begin
                res.quo = {res.quo[PH_W-2:0], 1'b0};
            end
            res.rem = sh[CNT_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [T_W-1:0] horner(logic [T_W-1:0] c, logic [T_W-1:0] r,
                                               logic [T_W-1:0] t2);
        logic [2*T_W-1:0] prod;
        prod = {{T_W{1'b0}}, r} * {{T_W{1'b0}}, t2};
        return c - prod[T_W+29:30];
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(logic signed [POS_W+1:0] v);
        logic signed [POS_W-1:0] res;
        if (v > 21'sd131071) begin
            res = 19'sd131071;
        end
        else if (v < -21'sd131072) begin
            res = -19'sd131072;
        end
        else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/tmcg_fifo.sv */
// ----------------------------------------------------------------------------
// Torus mesh cell generator word queue
// Small register-based first-in first-out queue with an occupancy count.
// ----------------------------------------------------------------------------
`include "torus_mesh_cell_generator_assert.svh"

module tmcg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [WIDTH-1:0]             wr_data,
    input  logic                         rd_en,
    output logic [WIDTH-1:0]             rd_data,
    output logic [$clog2(DEPTH+1)-1:0]   count,
    output logic                         empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (wr_en) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign count   = count_reg;
    assign empty   = (count_reg == '0);

    `TMCG_ASSERT_IMP(a_fifo_no_overflow, clk, rst_n, wr_en, count_reg < CW'(DEPTH), "Queue written while full.")
    `TMCG_ASSERT_IMP(a_fifo_no_underflow, clk, rst_n, rd_en, count_reg != '0, "Queue read while empty.")

endmodule

/* hw/rtl/tmcg_sine.sv */
// ----------------------------------------------------------------------------
// Torus mesh cell generator sine pipeline
// Seven-stage sine of a turn phase, odd polynomial by Horner's rule, Q1.14.
// ----------------------------------------------------------------------------
module tmcg_sine
    import tmcg_pkg::*;
(
    input  logic                    clk,
    input  logic [PH_W-1:0]         phase,
    output logic signed [NRM_W-1:0] sine
);

    logic [T_W-1:0]          t_reg   [6];
    logic                    neg_reg [6];
    logic [T_W-1:0]          t2_reg  [4];
    logic [T_W-1:0]          r7_reg;
    logic [T_W-1:0]          r5_reg;
    logic [T_W-1:0]          r3_reg;
    logic [T_W-1:0]          r1_reg;
    logic signed [NRM_W-1:0] sine_reg;

    logic [T_W-1:0]          t_next;
    logic [2*T_W-1:0]        sq_prod;
    logic [2*T_W-1:0]        s_prod;
    logic [PH_W-1:0]         s_val;
    logic [PH_W-1:0]         s_rnd;
    logic [NRM_W-2:0]        mag;
    logic signed [NRM_W-1:0] sine_next;

    always_comb begin
        t_next  = phase[PH_W-2] ? (ONE_Q30 - {1'b0, phase[PH_W-3:0]}) : {1'b0, phase[PH_W-3:0]};
        sq_prod = {{T_W{1'b0}}, t_reg[0]} * {{T_W{1'b0}}, t_reg[0]};
        s_prod  = {{T_W{1'b0}}, r1_reg} * {{T_W{1'b0}}, t_reg[5]};
        s_val   = s_prod[PH_W+29:30];
        if (s_val > {1'b0, ONE_Q30}) begin
            s_val = {1'b0, ONE_Q30};
        end
        s_rnd     = s_val + 32'd32768;
        mag       = s_rnd[T_W-1:16];
        sine_next = neg_reg[5] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge clk) begin
        t_reg[0]   <= t_next;
        neg_reg[0] <= phase[PH_W-1];
        for (int k = 1; k < 6; k++) begin
            t_reg[k]   <= t_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
        end
        t2_reg[0] <= sq_prod[T_W+29:30];
        for (int k = 1; k < 4; k++) begin
            t2_reg[k] <= t2_reg[k-1];
        end
        r7_reg   <= horner(SC7, SC9, t2_reg[0]);
        r5_reg   <= horner(SC5, r7_reg, t2_reg[1]);
        r3_reg   <= horner(SC3, r5_reg, t2_reg[2]);
        r1_reg   <= horner(SC1, r3_reg, t2_reg[3]);
        sine_reg <= sine_next;
    end

    assign sine = sine_reg;

endmodule

/* hw/rtl/tmcg_front.sv */
// ----------------------------------------------------------------------------
// Torus mesh cell generator front end
// Accepts cells, drops those outside the grid, computes vertex indices and
// the two turn phases through a pipelined divider, and fills the queue.
// ----------------------------------------------------------------------------
`include "torus_mesh_cell_generator_assert.svh"

module tmcg_front
    import tmcg_pkg::*;
#(
    parameter int QDEPTH = 8
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [IDX_W-1:0]              slice_index,
    input  logic [IDX_W-1:0]              stack_index,
    input  grid_cfg_t                     grid,
    input  logic [$clog2(QDEPTH+1)-1:0]   q_count,
    output logic                          q_wr,
    output mid_t                          q_data
);

    localparam int FR_LAT = DIV_STAGES + 1;
    localparam int IF_W   = $clog2(FR_LAT + 1);

    logic [FR_LAT-1:0] vld_reg;
    div_t              div_reg [FR_LAT];
    idx_t              idx_reg [FR_LAT];
    logic [IF_W-1:0]   inflight_reg;

    logic                 accept;
    logic                 in_grid;
    logic                 start;
    logic [CNT_W-1:0]     i_ext;
    logic [CNT_W-1:0]     j_ext;
    logic [CNT_W-1:0]     i_inc;
    logic [CNT_W-1:0]     j_inc;
    logic [CNT_W-1:0]     i_nx;
    logic [CNT_W-1:0]     j_nx;
    logic [2*CNT_W-1:0]   row_cur;
    logic [2*CNT_W-1:0]   row_nx;
    idx_t                 idx_new;
    div_t                 seed;

    assign full    = (int'(q_count) + int'(inflight_reg)) >= QDEPTH;
    assign accept  = push && !full;
    assign i_ext   = CNT_W'(slice_index);
    assign j_ext   = CNT_W'(stack_index);
    assign in_grid = (i_ext < grid.slices) && (j_ext < grid.stacks);
    assign start   = accept && in_grid;

    always_comb begin
        i_inc          = i_ext + 1'b1;
        j_inc          = j_ext + 1'b1;
        i_nx           = (i_inc == grid.slices) ? '0 : i_inc;
        j_nx           = (j_inc == grid.stacks) ? '0 : j_inc;
        row_cur        = {{CNT_W{1'b0}}, i_ext} * {{CNT_W{1'b0}}, grid.stacks};
        row_nx         = {{CNT_W{1'b0}}, i_nx} * {{CNT_W{1'b0}}, grid.stacks};
        idx_new.cur    = row_cur[VID_W-1:0] + VID_W'(j_ext);
        idx_new.nstack = row_cur[VID_W-1:0] + VID_W'(j_nx);
        idx_new.nslice = row_nx[VID_W-1:0] + VID_W'(j_ext);
        idx_new.nboth  = row_nx[VID_W-1:0] + VID_W'(j_nx);
        seed.a.rem     = i_ext;
        seed.a.quo     = '0;
        seed.b.rem     = j_ext;
        seed.b.quo     = '0;
    end

    always_ff @(posedge clk) begin
        div_reg[0] <= seed;
        idx_reg[0] <= idx_new;
        for (int k = 1; k < FR_LAT; k++) begin
            div_reg[k].a <= div_step(div_reg[k-1].a, grid.slices);
            div_reg[k].b <= div_step(div_reg[k-1].b, grid.stacks);
            idx_reg[k]   <= idx_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg      <= '0;
            inflight_reg <= '0;
        end
        else begin
            vld_reg <= {vld_reg[FR_LAT-2:0], start};
            unique case ({start, vld_reg[FR_LAT-1]})
                2'b10:   inflight_reg <= inflight_reg + 1'b1;
                2'b01:   inflight_reg <= inflight_reg - 1'b1;
                default: inflight_reg <= inflight_reg;
            endcase
        end
    end

    assign q_wr        = vld_reg[FR_LAT-1];
    assign q_data.pa   = div_reg[FR_LAT-1].a.quo;
    assign q_data.pb   = div_reg[FR_LAT-1].b.quo;
    assign q_data.idx  = idx_reg[FR_LAT-1];

    `TMCG_ASSERT_ALWAYS(a_front_inflight, clk, rst_n, inflight_reg == $countones(vld_reg), "Front in-flight count lost track of the pipeline.")

endmodule

/* hw/rtl/tmcg_back.sv */
// ----------------------------------------------------------------------------
// Torus mesh cell generator back end
// Takes phases from the queue, runs four sine pipelines and the position
// and normal arithmetic, and writes finished cells to the result queue.
// ----------------------------------------------------------------------------
`include "torus_mesh_cell_generator_assert.svh"

module tmcg_back
    import tmcg_pkg::*;
#(
    parameter int ODEPTH = 8
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  geom_cfg_t                     geom,
    input  logic                          q_empty,
    input  mid_t                          q_head,
    output logic                          q_rd,
    input  logic [$clog2(ODEPTH+1)-1:0]   o_count,
    output logic                          o_wr,
    output out_t                          o_data
);

    localparam int SIN_LAT = 7;
    localparam int BK_LAT  = SIN_LAT + 3;
    localparam int IF_W    = $clog2(BK_LAT + 1);

    logic [BK_LAT-1:0]       vld_reg;
    logic [IF_W-1:0]         inflight_reg;
    side_t                   side_reg [BK_LAT-1];

    logic signed [32:0]      ring_reg;
    logic signed [32:0]      ycross_reg;
    logic signed [31:0]      ncx_reg;
    logic signed [31:0]      ncz_reg;
    logic signed [NRM_W-1:0] ca_g0_reg;
    logic signed [NRM_W-1:0] sa_g0_reg;
    logic signed [NRM_W-1:0] sb_g0_reg;

    logic signed [48:0]      pxp_reg;
    logic signed [48:0]      pzp_reg;
    logic signed [POS_W-1:0] py_reg;
    logic signed [NRM_W-1:0] nx_reg;
    logic signed [NRM_W-1:0] ny_reg;
    logic signed [NRM_W-1:0] nz_reg;
    out_t                    out_reg;

    logic signed [NRM_W-1:0] sa;
    logic signed [NRM_W-1:0] ca;
    logic signed [NRM_W-1:0] sb;
    logic signed [NRM_W-1:0] cb;
    logic                    go;
    side_t                   side_new;
    logic signed [16:0]      tube_s;
    logic signed [32:0]      major_s;
    logic signed [32:0]      tube_cb;
    logic signed [32:0]      ysum;
    logic signed [31:0]      nxsum;
    logic signed [31:0]      nzsum;
    logic signed [48:0]      pxs;
    logic signed [48:0]      pzs;

    assign go = !q_empty && ((int'(o_count) + int'(inflight_reg)) < ODEPTH);
    assign q_rd = go;

    tmcg_sine u_sin_a (.clk(clk), .phase(q_head.pa), .sine(sa));
    tmcg_sine u_cos_a (.clk(clk), .phase(q_head.pa + QUARTER_TURN), .sine(ca));
    tmcg_sine u_sin_b (.clk(clk), .phase(q_head.pb), .sine(sb));
    tmcg_sine u_cos_b (.clk(clk), .phase(q_head.pb + QUARTER_TURN), .sine(cb));

    always_comb begin
        side_new.tex_u = q_head.pa[PH_W-1:PH_W-TEX_W];
        side_new.tex_v = q_head.pb[PH_W-1:PH_W-TEX_W];
        side_new.idx   = q_head.idx;
        tube_s         = $signed({1'b0, geom.tube});
        major_s        = $signed({3'b000, geom.major, 14'd0});
        tube_cb        = 33'(tube_s) * 33'(cb);
        ysum           = ycross_reg + 33'sd8192;
        nxsum          = ncx_reg + 32'sd8192;
        nzsum          = ncz_reg + 32'sd8192;
        pxs            = pxp_reg + 49'sd134217728;
        pzs            = pzp_reg + 49'sd134217728;
    end

    always_ff @(posedge clk) begin
        side_reg[0] <= side_new;
        for (int k = 1; k < BK_LAT - 1; k++) begin
            side_reg[k] <= side_reg[k-1];
        end

        ring_reg   <= tube_cb - major_s;
        ycross_reg <= 33'(tube_s) * 33'(sb);
        ncx_reg    <= 32'(cb) * 32'(ca);
        ncz_reg    <= 32'(cb) * 32'(sa);
        ca_g0_reg  <= ca;
        sa_g0_reg  <= sa;
        sb_g0_reg  <= sb;

        pxp_reg <= 49'(ring_reg) * 49'(ca_g0_reg);
        pzp_reg <= 49'(ring_reg) * 49'(sa_g0_reg);
        py_reg  <= ysum[32:14];
        nx_reg  <= nxsum[29:14];
        ny_reg  <= sb_g0_reg;
        nz_reg  <= nzsum[29:14];

        out_reg.pos_x  <= clamp_pos(pxs[48:28]);
        out_reg.pos_y  <= py_reg;
        out_reg.pos_z  <= clamp_pos(pzs[48:28]);
        out_reg.norm_x <= nx_reg;
        out_reg.norm_y <= ny_reg;
        out_reg.norm_z <= nz_reg;
        out_reg.side   <= side_reg[BK_LAT-2];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg      <= '0;
            inflight_reg <= '0;
        end
        else begin
            vld_reg <= {vld_reg[BK_LAT-2:0], go};
            unique case ({go, vld_reg[BK_LAT-1]})
                2'b10:   inflight_reg <= inflight_reg + 1'b1;
                2'b01:   inflight_reg <= inflight_reg - 1'b1;
                default: inflight_reg <= inflight_reg;
            endcase
        end
    end

    assign o_wr   = vld_reg[BK_LAT-1];
    assign o_data = out_reg;

    `TMCG_ASSERT_ALWAYS(a_back_inflight, clk, rst_n, inflight_reg == $countones(vld_reg), "Back in-flight count lost track of the pipeline.")

endmodule

/* hw/rtl/torus_mesh_cell_generator.sv */
// ----------------------------------------------------------------------------
// Torus mesh cell generator
// Turns one grid cell of a torus into its vertex and its two triangles.
// ----------------------------------------------------------------------------
// A cell (slice_index, stack_index) is written with push while full is low.
// Each cell inside the configured grid yields three words on the result side,
// in order: the vertex (kind 0), then the first and second triangle (kind 1
// and 2). A cell outside the grid is taken and yields nothing. A result word
// is shown while empty is low and is taken with pop.
// A cell is held by three result words at the single result port. The
// divider pipeline accepts a cell every cycle while full is low, and the
// sine pipelines accept one every cycle while the middle queue holds a cell
// and the result queue has room.
// When pop stays low, the result queue fills, the back end stops drawing
// from the middle queue, and full rises once that queue and the front
// pipeline are committed; nothing is lost.
// Reset empties both queues and sets the registers to 16 slices, 16 stacks,
// major radius 1.0 and tube radius 0.5. Registers must be written over the
// APB port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module torus_mesh_cell_generator
    import tmcg_pkg::*;
#(
    parameter int MAX_SLICES = 256,
    parameter int MAX_STACKS = 256
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [IDX_W-1:0]        slice_index,
    input  logic [IDX_W-1:0]        stack_index,
    input  logic                    pop,
    output logic                    empty,
    output logic [KIND_W-1:0]       kind,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    output logic signed [POS_W-1:0] pos_z,
    output logic signed [NRM_W-1:0] norm_x,
    output logic signed [NRM_W-1:0] norm_y,
    output logic signed [NRM_W-1:0] norm_z,
    output logic [TEX_W-1:0]        tex_u,
    output logic [TEX_W-1:0]        tex_v,
    output logic [VID_W-1:0]        corner_a,
    output logic [VID_W-1:0]        corner_b,
    output logic [VID_W-1:0]        corner_c,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int QDEPTH = 8;
    localparam int ODEPTH = 8;
    localparam int SLICE_CAP = (MAX_SLICES < (1 << CNT_W)) ? MAX_SLICES : (1 << CNT_W) - 1;
    localparam int STACK_CAP = (MAX_STACKS < (1 << CNT_W)) ? MAX_STACKS : (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] SLICE_MAX = CNT_W'(SLICE_CAP);
    localparam logic [CNT_W-1:0] STACK_MAX = CNT_W'(STACK_CAP);

    logic [CNT_W-1:0]  slice_count_reg;
    logic [CNT_W-1:0]  stack_count_reg;
    logic [RAD_W-1:0]  major_radius_reg;
    logic [RAD_W-1:0]  tube_radius_reg;
    logic [KIND_W-1:0] kind_reg;

    logic                          cfg_wr;
    logic [CNT_W-1:0]              wr_cnt;
    logic [CNT_W-1:0]              slice_next;
    logic [CNT_W-1:0]              stack_next;
    grid_cfg_t                     grid;
    geom_cfg_t                     geom;
    logic                          q_wr;
    logic                          q_rd;
    logic                          q_empty;
    mid_t                          q_wdata;
    mid_t                          q_head;
    logic [$clog2(QDEPTH+1)-1:0]   q_count;
    logic                          o_wr;
    logic                          o_rd;
    out_t                          o_wdata;
    out_t                          o_head;
    logic [$clog2(ODEPTH+1)-1:0]   o_count;
    logic                          is_vtx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign wr_cnt = pwdata[CNT_W-1:0];

    always_comb begin
        if (wr_cnt == '0) begin
            slice_next = CNT_W'(1);
            stack_next = CNT_W'(1);
        end
        else begin
            slice_next = (wr_cnt > SLICE_MAX) ? SLICE_MAX : wr_cnt;
            stack_next = (wr_cnt > STACK_MAX) ? STACK_MAX : wr_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            slice_count_reg  <= CNT_W'(16);
            stack_count_reg  <= CNT_W'(16);
            major_radius_reg <= RAD_W'(256);
            tube_radius_reg  <= RAD_W'(128);
        end
        else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SLICES: slice_count_reg  <= slice_next;
                REG_STACKS: stack_count_reg  <= stack_next;
                REG_MAJOR:  major_radius_reg <= pwdata[RAD_W-1:0];
                REG_TUBE:   tube_radius_reg  <= pwdata[RAD_W-1:0];
                default:    slice_count_reg  <= slice_count_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SLICES: prdata = 32'(slice_count_reg);
            REG_STACKS: prdata = 32'(stack_count_reg);
            REG_MAJOR:  prdata = 32'(major_radius_reg);
            REG_TUBE:   prdata = 32'(tube_radius_reg);
            default:    prdata = '0;
        endcase
    end

    assign grid.slices = slice_count_reg;
    assign grid.stacks = stack_count_reg;
    assign geom.major  = major_radius_reg;
    assign geom.tube   = tube_radius_reg;

    tmcg_front #(
        .QDEPTH(QDEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .slice_index (slice_index),
        .stack_index (stack_index),
        .grid        (grid),
        .q_count     (q_count),
        .q_wr        (q_wr),
        .q_data      (q_wdata)
    );

    tmcg_fifo #(
        .WIDTH($bits(mid_t)),
        .DEPTH(QDEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .rd_en   (q_rd),
        .rd_data (q_head),
        .count   (q_count),
        .empty   (q_empty)
    );

    tmcg_back #(
        .ODEPTH(ODEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .geom    (geom),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_rd    (q_rd),
        .o_count (o_count),
        .o_wr    (o_wr),
        .o_data  (o_wdata)
    );

    tmcg_fifo #(
        .WIDTH($bits(out_t)),
        .DEPTH(ODEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (o_wr),
        .wr_data (o_wdata),
        .rd_en   (o_rd),
        .rd_data (o_head),
        .count   (o_count),
        .empty   (empty)
    );

    assign o_rd = pop && !empty && (kind_reg == KIND_TRI2);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            kind_reg <= KIND_VERTEX;
        end
        else if (pop && !empty) begin
            kind_reg <= (kind_reg == KIND_TRI2) ? KIND_VERTEX : kind_reg + 1'b1;
        end
    end

    assign is_vtx = (kind_reg == KIND_VERTEX);
    assign kind   = kind_reg;
    assign pos_x  = is_vtx ? o_head.pos_x : '0;
    assign pos_y  = is_vtx ? o_head.pos_y : '0;
    assign pos_z  = is_vtx ? o_head.pos_z : '0;
    assign norm_x = is_vtx ? o_head.norm_x : '0;
    assign norm_y = is_vtx ? o_head.norm_y : '0;
    assign norm_z = is_vtx ? o_head.norm_z : '0;
    assign tex_u  = is_vtx ? o_head.side.tex_u : '0;
    assign tex_v  = is_vtx ? o_head.side.tex_v : '0;

    always_comb begin
        unique case (kind_reg)
            KIND_TRI1: begin
                corner_a = o_head.side.idx.cur;
                corner_b = o_head.side.idx.nslice;
                corner_c = o_head.side.idx.nstack;
            end
            KIND_TRI2: begin
                corner_a = o_head.side.idx.nstack;
                corner_b = o_head.side.idx.nslice;
                corner_c = o_head.side.idx.nboth;
            end
            default: begin
                corner_a = '0;
                corner_b = '0;
                corner_c = '0;
            end
        endcase
    end

endmodule

/* test/torus_mesh_cell_generator_checker.sv */
// ----------------------------------------------------------------------------
// Torus mesh cell generator checker
// Watches the cell, result and register ports, predicts the three words of
// every cell inside the grid and compares each popped word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module torus_mesh_cell_checker
    import tmcg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic                    full,
    input  logic [IDX_W-1:0]        slice_index,
    input  logic [IDX_W-1:0]        stack_index,
    input  logic                    pop,
    input  logic                    empty,
    input  logic [KIND_W-1:0]       kind,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic signed [NRM_W-1:0] norm_x,
    input  logic signed [NRM_W-1:0] norm_y,
    input  logic signed [NRM_W-1:0] norm_z,
    input  logic [TEX_W-1:0]        tex_u,
    input  logic [TEX_W-1:0]        tex_v,
    input  logic [VID_W-1:0]        corner_a,
    input  logic [VID_W-1:0]        corner_b,
    input  logic [VID_W-1:0]        corner_c,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    input  logic                    pready,
    output int                      failures,
    output int                      words_pending,
    output int                      cells_taken,
    output int                      words_checked
);

    typedef struct {
        logic [KIND_W-1:0]       kind;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic [TEX_W-1:0]        u;
        logic [TEX_W-1:0]        v;
        logic [VID_W-1:0]        a;
        logic [VID_W-1:0]        b;
        logic [VID_W-1:0]        c;
    } mesh_word_t;

    localparam longint unsigned Q30 = 64'd1073741824;

    mesh_word_t      mesh_words[$];
    longint unsigned n_slices = 16;
    longint unsigned n_stacks = 16;
    longint unsigned r_major  = 256;
    longint unsigned r_tube   = 128;

    assign words_pending = mesh_words.size();

    function automatic longint quarter_sine(longint unsigned t);
        longint unsigned t2;
        longint unsigned r;
        longint unsigned s;
        t2 = (t * t) >> 30;
        r = 64'd172272;
        r = 64'd5026995 - ((r * t2) >> 30);
        r = 64'd85569306 - ((r * t2) >> 30);
        r = 64'd693598667 - ((r * t2) >> 30);
        r = 64'd1686629713 - ((r * t2) >> 30);
        s = (r * t) >> 30;
        if (s > Q30)
        begin
            s = Q30;
        end
        return longint'((s + 64'd32768) >> 16);
    endfunction

    function automatic longint turn_sine(longint unsigned p);
        longint unsigned q;
        longint unsigned f;
        p = p & 64'hFFFF_FFFF;
        q = p >> 30;
        f = p & (Q30 - 1);
        case (q)
            0: return quarter_sine(f);
            1: return quarter_sine(Q30 - f);
            2: return -quarter_sine(f);
            default: return -quarter_sine(Q30 - f);
        endcase
    endfunction

    function automatic longint round_shift(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(longint v);
        if (v > 131071)
        begin
            return 19'sd131071;
        end
        if (v < -131072)
        begin
            return -19'sd131072;
        end
        return v[POS_W-1:0];
    endfunction

    function automatic longint unsigned count_limit(logic [31:0] value);
        longint unsigned n;
        n = longint'(value[CNT_W-1:0]);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > 256)
        begin
            n = 256;
        end
        return n;
    endfunction

    task automatic predict_cell(longint unsigned i, longint unsigned j);
        mesh_word_t      w;
        longint unsigned pa;
        longint unsigned pb;
        longint unsigned cur;
        longint unsigned nstack;
        longint unsigned nslice;
        longint unsigned nboth;
        longint unsigned side;
        longint          sa;
        longint          ca;
        longint          sb;
        longint          cb;
        longint          ring;
        longint          t;
        if (i >= n_slices || j >= n_stacks)
        begin
            return;
        end
        pa = (i << 32) / n_slices;
        pb = (j << 32) / n_stacks;
        sa = turn_sine(pa);
        ca = turn_sine(pa + Q30);
        sb = turn_sine(pb);
        cb = turn_sine(pb + Q30);
        ring = -longint'(r_major) * 16384 + longint'(r_tube) * cb;
        w = '{default: '0};
        w.kind = KIND_VERTEX;
        w.px = sat_pos(round_shift(ring * ca, 28));
        w.py = sat_pos(round_shift(longint'(r_tube) * sb, 14));
        w.pz = sat_pos(round_shift(ring * sa, 28));
        t = round_shift(cb * ca, 14);
        w.nx = t[NRM_W-1:0];
        w.ny = sb[NRM_W-1:0];
        t = round_shift(cb * sa, 14);
        w.nz = t[NRM_W-1:0];
        w.u = TEX_W'((i << 16) / n_slices);
        w.v = TEX_W'((j << 16) / n_stacks);
        mesh_words = {mesh_words, w};
        cur = i * n_stacks + j;
        nstack = i * n_stacks + (j + 1) % n_stacks;
        side = ((i + 1) % n_slices) * n_stacks;
        nslice = side + j;
        nboth = side + (j + 1) % n_stacks;
        w = '{default: '0};
        w.kind = KIND_TRI1;
        w.a = cur[VID_W-1:0];
        w.b = nslice[VID_W-1:0];
        w.c = nstack[VID_W-1:0];
        mesh_words = {mesh_words, w};
        w.kind = KIND_TRI2;
        w.a = nstack[VID_W-1:0];
        w.b = nslice[VID_W-1:0];
        w.c = nboth[VID_W-1:0];
        mesh_words = {mesh_words, w};
    endtask

    task automatic compare_word();
        mesh_word_t w;
        if (mesh_words.size() == 0)
        begin
            $error("unexpected word: kind %0d", kind);
            failures++;
            return;
        end
        w = mesh_words.pop_front();
        words_checked++;
        if (kind !== w.kind)
        begin
            $error("kind: expected %0d, got %0d", w.kind, kind);
            failures++;
        end
        if (pos_x !== w.px)
        begin
            $error("pos_x: expected %0d, got %0d", w.px, pos_x);
            failures++;
        end
        if (pos_y !== w.py)
        begin
            $error("pos_y: expected %0d, got %0d", w.py, pos_y);
            failures++;
        end
        if (pos_z !== w.pz)
        begin
            $error("pos_z: expected %0d, got %0d", w.pz, pos_z);
            failures++;
        end
        if (norm_x !== w.nx)
        begin
            $error("norm_x: expected %0d, got %0d", w.nx, norm_x);
            failures++;
        end
        if (norm_y !== w.ny)
        begin
            $error("norm_y: expected %0d, got %0d", w.ny, norm_y);
            failures++;
        end
        if (norm_z !== w.nz)
        begin
            $error("norm_z: expected %0d, got %0d", w.nz, norm_z);
            failures++;
        end
        if (tex_u !== w.u)
        begin
            $error("tex_u: expected %0d, got %0d", w.u, tex_u);
            failures++;
        end
        if (tex_v !== w.v)
        begin
            $error("tex_v: expected %0d, got %0d", w.v, tex_v);
            failures++;
        end
        if (corner_a !== w.a)
        begin
            $error("corner_a: expected %0d, got %0d", w.a, corner_a);
            failures++;
        end
        if (corner_b !== w.b)
        begin
            $error("corner_b: expected %0d, got %0d", w.b, corner_b);
            failures++;
        end
        if (corner_c !== w.c)
        begin
            $error("corner_c: expected %0d, got %0d", w.c, corner_c);
            failures++;
        end
    endtask

    initial
    begin
        failures = 0;
        cells_taken = 0;
        words_checked = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                compare_word();
            end
            if (push && !full)
            begin
                cells_taken++;
                predict_cell(longint'(slice_index), longint'(stack_index));
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_SLICES: n_slices = count_limit(pwdata);
                    REG_STACKS: n_stacks = count_limit(pwdata);
                    REG_MAJOR:  r_major = longint'(pwdata[RAD_W-1:0]);
                    REG_TUBE:   r_tube = longint'(pwdata[RAD_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Torus mesh cell generator testbench
// Drives grid cells and register settings with random idling on both sides,
// including one long result stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import tmcg_pkg::*;

    localparam int STALL_LIMIT = 3000;

    logic                    clk;
    logic                    rst_n;
    logic                    push;
    logic                    full;
    logic [IDX_W-1:0]        slice_index;
    logic [IDX_W-1:0]        stack_index;
    logic                    pop;
    logic                    empty;
    logic [KIND_W-1:0]       kind;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] norm_x;
    logic signed [NRM_W-1:0] norm_y;
    logic signed [NRM_W-1:0] norm_z;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic [VID_W-1:0]        corner_a;
    logic [VID_W-1:0]        corner_b;
    logic [VID_W-1:0]        corner_c;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [3:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    int failures;
    int words_pending;
    int cells_taken;
    int words_checked;
    int cells_sent;
    int idle_cycles;
    int grid_slices;
    int grid_stacks;
    bit calm;

    torus_mesh_cell_generator i_dut (.*);

    torus_mesh_cell_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (index == REG_SLICES || index == REG_STACKS)
        begin
            value = value & 32'h1FF;
            if (value < 1) value = 1;
            if (value > 256) value = 256;
            if (index == REG_SLICES) grid_slices = value;
            else grid_stacks = value;
        end
    endtask

    task automatic send_cell(int i, int j);
        bit taken;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        push        <= 1'b1;
        slice_index <= IDX_W'(i);
        stack_index <= IDX_W'(j);
        do
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end
        while (!taken);
        cells_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (words_pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_grid(int s, int t, int rm, int rt);
        write_reg(REG_SLICES, s);
        write_reg(REG_STACKS, t);
        write_reg(REG_MAJOR, rm);
        write_reg(REG_TUBE, rt);
    endtask

    task automatic random_cells(int n);
        int i;
        int j;
        repeat (n)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                i = $urandom_range(0, grid_slices - 1);
                j = $urandom_range(0, grid_stacks - 1);
            end
            else
            begin
                i = $urandom_range(0, 255);
                j = $urandom_range(0, 255);
            end
            send_cell(i, j);
        end
    endtask

    initial
    begin
        bit held;
        held = 1'b0;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && cells_sent >= 45)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        slice_index = '0;
        stack_index = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        idle_cycles = 0;
        cells_sent  = 0;
        calm        = 1'b0;
        grid_slices = 16;
        grid_stacks = 16;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cell(0, 0);
        send_cell(15, 15);
        send_cell(4, 4);
        send_cell(8, 8);
        send_cell(12, 12);
        send_cell(16, 0);
        send_cell(0, 16);
        send_cell(255, 255);
        drain();
        set_grid(256, 256, 16'hFFFF, 16'hFFFF);
        send_cell(255, 255);
        send_cell(0, 0);
        send_cell(128, 64);
        send_cell(200, 100);
        send_cell(64, 192);
        drain();
        set_grid(0, 32'h3FF, 0, 0);
        send_cell(0, 0);
        send_cell(0, 255);
        send_cell(1, 0);
        drain();
        set_grid(3, 1, 16'h8000, 16'hFFFF);
        send_cell(2, 0);
        send_cell(0, 0);
        send_cell(1, 1);
        drain();

        set_grid(256, 256, $urandom_range(0, 65535), $urandom_range(0, 65535));
        random_cells(40);
        drain();
        set_grid($urandom_range(1, 40), $urandom_range(1, 40),
                 $urandom_range(0, 2048), $urandom_range(0, 1024));
        random_cells(35);
        drain();
        set_grid($urandom_range(0, 511), $urandom_range(0, 511),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
        random_cells(35);
        drain();
        calm = 1'b1;
        set_grid($urandom_range(100, 256), $urandom_range(100, 256),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
        random_cells(40);
        drain();

        $display("Cells taken: %0d, result words checked: %0d.", cells_taken, words_checked);
        $display("Settings covered reset values, extreme counts and radii, and random grids.");
        if (failures == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
